@@ rtl/lcbam_pkg.sv @@
// lcbam_pkg: constants and helpers for the led cube bit angle modulation scan driver
// no dependencies; imported by led_cube_bam_scan_driver_top

package lcbam_pkg;

    localparam int PLANE_COUNT = 12;
    localparam int ROW_BITS    = PLANE_COUNT * 8;
    localparam int ROW_DEPTH   = 64;

    localparam logic [4:0] ROW_BEATS   = 5'd24;
    localparam logic [6:0] FRAME_TICKS = 7'd120;
    localparam logic [6:0] STEP_TICK_A = 7'd8;
    localparam logic [6:0] STEP_TICK_B = 7'd24;
    localparam logic [6:0] STEP_TICK_C = 7'd56;
    localparam logic [1:0] TOP_WEIGHT  = 2'd3;
    localparam logic [7:0] LAYER_SEL_TOP = 8'h80;

    function automatic logic [2:0] clamp_coord(input logic signed [4:0] raw);
        logic [2:0] v;
        if (raw[4])
        begin
            v = 3'd0;
        end
        else if (raw[3])
        begin
            v = 3'd7;
        end
        else
        begin
            v = raw[2:0];
        end
        return v;
    endfunction

    function automatic logic [3:0] clamp_color(input logic [7:0] raw);
        logic [3:0] v;
        if (|raw[7:4])
        begin
            v = 4'hF;
        end
        else
        begin
            v = raw[3:0];
        end
        return v;
    endfunction

endpackage

@@ rtl/led_cube_bam_scan_driver_top.sv @@
// led_cube_bam_scan_driver_top: bit plane store and refresh scan for an 8x8x8 rgb cube
// depends on lcbam_pkg
//
// channel  dir  handshake            fields
// in       in   in_valid / in_stall  mode layer row column red green blue
// out      out  out_valid / out_stall shift_byte last
//
// a write beat reads the 96-bit row in S_WR_READ, then merges and writes it back in S_WR_MERGE
// a tick beat gives 25 output beats, one per cycle when out is not stalled;
// the single read port of the row store paces the scan
// the store reads as zero after reset through one valid bit per row, no clearing pass
// out_stall holds the output register and pauses the row reads; in_stall is high while busy

module led_cube_bam_scan_driver_top #(
    parameter int LAYER_COUNT = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              mode,
    input  logic signed [4:0] layer,
    input  logic signed [4:0] row,
    input  logic signed [4:0] column,
    input  logic        [7:0] red,
    input  logic        [7:0] green,
    input  logic        [7:0] blue,
    output logic              out_valid,
    input  logic              out_stall,
    output logic        [7:0] shift_byte,
    output logic              last
);

    import lcbam_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WR_READ,
        S_WR_MERGE,
        S_TICK
    } state_t;

    state_t state_reg, state_next;

    logic [6:0] tick_count_reg, tick_count_next;
    logic [1:0] weight_bit_reg, weight_bit_next;
    logic [1:0] shown_bit_reg, shown_bit_next;
    logic [2:0] scan_layer_reg, scan_layer_next;
    logic [4:0] iss_cnt_reg, iss_cnt_next;
    logic [4:0] ld_cnt_reg, ld_cnt_next;
    logic       rd_pend_reg, rd_pend_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] shift_byte_reg, shift_byte_next;
    logic       last_reg, last_next;

    logic [5:0] wr_row_reg, wr_row_next;
    logic [2:0] wr_col_reg, wr_col_next;
    logic [3:0] wr_red_reg, wr_red_next;
    logic [3:0] wr_green_reg, wr_green_next;
    logic [3:0] wr_blue_reg, wr_blue_next;

    logic [ROW_BITS-1:0]  frame_mem [ROW_DEPTH];
    logic [ROW_DEPTH-1:0] row_valid_reg;
    logic [ROW_BITS-1:0]  rd_data_reg;
    logic                 rd_hit_reg;

    logic                 in_accept;
    logic                 out_free;
    logic                 rd_en;
    logic [5:0]           rd_addr;
    logic                 wr_en;
    logic [ROW_BITS-1:0]  wr_data;
    logic                 step_hit;
    logic [1:0]           weight_inc;
    logic [6:0]           tick_inc;
    logic                 issue;
    logic                 load;
    logic [3:0]           plane;
    logic [2:0]           layer_last;

    assign in_stall   = (state_reg != S_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign out_valid  = out_valid_reg;
    assign shift_byte = shift_byte_reg;
    assign last       = last_reg;
    assign layer_last = 3'(LAYER_COUNT - 1);

    assign step_hit   = (tick_count_reg == STEP_TICK_A) || (tick_count_reg == STEP_TICK_B)
                     || (tick_count_reg == STEP_TICK_C);
    assign weight_inc = weight_bit_reg + {1'b0, step_hit};
    assign tick_inc   = tick_count_reg + 7'd1;

    assign issue   = (state_reg == S_TICK) && (iss_cnt_reg != ROW_BEATS)
                  && (!rd_pend_reg || out_free);
    assign load    = (state_reg == S_TICK) && rd_pend_reg && out_free;
    assign plane   = {ld_cnt_reg[4:3], shown_bit_reg};
    assign rd_en   = (state_reg == S_WR_READ) || issue;
    assign rd_addr = (state_reg == S_WR_READ) ? wr_row_reg : {scan_layer_reg, iss_cnt_reg[2:0]};
    assign wr_en   = (state_reg == S_WR_MERGE);

    always_comb
    begin
        wr_data = rd_hit_reg ? rd_data_reg : '0;
        for (int b = 0; b < 4; b++)
        begin
            wr_data[{2'd0, 2'(b), wr_col_reg}] = wr_red_reg[b];
            wr_data[{2'd1, 2'(b), wr_col_reg}] = wr_green_reg[b];
            wr_data[{2'd2, 2'(b), wr_col_reg}] = wr_blue_reg[b];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        tick_count_next = tick_count_reg;
        weight_bit_next = weight_bit_reg;
        shown_bit_next  = shown_bit_reg;
        scan_layer_next = scan_layer_reg;
        iss_cnt_next    = iss_cnt_reg;
        ld_cnt_next     = ld_cnt_reg;
        rd_pend_next    = rd_pend_reg;
        out_valid_next  = out_valid_reg && out_stall;
        shift_byte_next = shift_byte_reg;
        last_next       = last_reg;
        wr_row_next     = wr_row_reg;
        wr_col_next     = wr_col_reg;
        wr_red_next     = wr_red_reg;
        wr_green_next   = wr_green_reg;
        wr_blue_next    = wr_blue_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (!mode)
                    begin
                        wr_row_next   = {clamp_coord(layer), clamp_coord(row)};
                        wr_col_next   = clamp_coord(column);
                        wr_red_next   = clamp_color(red);
                        wr_green_next = clamp_color(green);
                        wr_blue_next  = clamp_color(blue);
                        state_next    = S_WR_READ;
                    end
                    else
                    begin
                        shown_bit_next = weight_inc;
                        if (weight_inc == TOP_WEIGHT && tick_inc == FRAME_TICKS)
                        begin
                            tick_count_next = '0;
                            weight_bit_next = '0;
                        end
                        else
                        begin
                            tick_count_next = tick_inc;
                            weight_bit_next = weight_inc;
                        end
                        iss_cnt_next = '0;
                        ld_cnt_next  = '0;
                        rd_pend_next = 1'b0;
                        state_next   = S_TICK;
                    end
                end
            end
            S_WR_READ:
            begin
                state_next = S_WR_MERGE;
            end
            S_WR_MERGE:
            begin
                state_next = S_IDLE;
            end
            S_TICK:
            begin
                if (issue)
                begin
                    iss_cnt_next = iss_cnt_reg + 5'd1;
                    rd_pend_next = 1'b1;
                end
                else if (load)
                begin
                    rd_pend_next = 1'b0;
                end
                if (load)
                begin
                    shift_byte_next = rd_hit_reg ? rd_data_reg[{plane, 3'd0} +: 8] : 8'h00;
                    last_next       = 1'b0;
                    out_valid_next  = 1'b1;
                    ld_cnt_next     = ld_cnt_reg + 5'd1;
                end
                else if (ld_cnt_reg == ROW_BEATS && out_free)
                begin
                    shift_byte_next = LAYER_SEL_TOP >> scan_layer_reg;
                    last_next       = 1'b1;
                    out_valid_next  = 1'b1;
                    scan_layer_next = (scan_layer_reg == layer_last) ? 3'd0
                                                                     : scan_layer_reg + 3'd1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tick_count_reg <= '0;
            weight_bit_reg <= '0;
            shown_bit_reg  <= '0;
            scan_layer_reg <= '0;
            iss_cnt_reg    <= '0;
            ld_cnt_reg     <= '0;
            rd_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            shift_byte_reg <= '0;
            last_reg       <= 1'b0;
            wr_row_reg     <= '0;
            wr_col_reg     <= '0;
            wr_red_reg     <= '0;
            wr_green_reg   <= '0;
            wr_blue_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            tick_count_reg <= tick_count_next;
            weight_bit_reg <= weight_bit_next;
            shown_bit_reg  <= shown_bit_next;
            scan_layer_reg <= scan_layer_next;
            iss_cnt_reg    <= iss_cnt_next;
            ld_cnt_reg     <= ld_cnt_next;
            rd_pend_reg    <= rd_pend_next;
            out_valid_reg  <= out_valid_next;
            shift_byte_reg <= shift_byte_next;
            last_reg       <= last_next;
            wr_row_reg     <= wr_row_next;
            wr_col_reg     <= wr_col_next;
            wr_red_reg     <= wr_red_next;
            wr_green_reg   <= wr_green_next;
            wr_blue_reg    <= wr_blue_next;
        end
    end

    // row store, one read and one write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            frame_mem[wr_row_reg] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= frame_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_hit_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_row_reg] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= row_valid_reg[rd_addr];
            end
        end
    end

endmodule
